// File: rtl/mbsw_pkg.sv
// Package for the quadratic B-spline weight core: payload types, widths and
// the per-axis helper functions shared by the front, queue and back modules.
// No dependencies.
package mbsw_pkg;

  localparam int PosW     = 32;
  localparam int NodeW    = 16;
  localparam int WtW      = 16;
  localparam int GradW    = 32;
  localparam int InvW     = 29;
  localparam int BaseW    = 17;
  localparam int FracW    = 16;
  localparam int AxWW     = 32;
  localparam int DwW      = 18;
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 32;

  // register map (index = word address)
  localparam logic RegInvCellSize = 1'b0;
  localparam logic [InvW-1:0] InvCellSizeRst = 29'd1966080;

  // stencil offsets along one axis
  localparam logic [1:0] NodeLo  = 2'd0;
  localparam logic [1:0] NodeMid = 2'd1;
  localparam logic [1:0] NodeHi  = 2'd2;

  typedef logic signed [PosW-1:0]  pos_t;
  typedef logic signed [NodeW-1:0] node_t;
  typedef logic [WtW-1:0]          wt_t;
  typedef logic signed [GradW-1:0] grad_t;
  typedef logic [InvW-1:0]         inv_t;
  typedef logic [AxWW-1:0]         axw_t;
  typedef logic signed [DwW-1:0]   dw_t;

  // one axis of a particle: stencil base, fraction and the three weights
  typedef struct packed {
    logic signed [BaseW-1:0] base;
    logic [FracW-1:0]        frac;
    axw_t                    w0;
    axw_t                    w1;
    axw_t                    w2;
  } axis_t;

  typedef struct packed {
    axis_t x;
    axis_t y;
    axis_t z;
  } part_t;

  // base = floor(p - 0.5), frac and Q0.32 weights, halves rounded up
  function automatic axis_t axis_setup(pos_t p);
    logic signed [32:0] ps;
    logic [15:0]        f;
    logic [16:0]        a;
    logic [33:0]        aa;
    logic [33:0]        aa1;
    logic [15:0]        cm;
    logic [31:0]        cc;
    logic [31:0]        ff;
    logic [32:0]        ff1;
    axis_t              r;
    ps  = {p[31], p} - 33'sd32768;
    f   = ps[15:0];
    a   = 17'd65536 - {1'b0, f};
    aa  = 34'(a) * 34'(a);
    aa1 = aa + 34'd1;
    cm  = f[15] ? {1'b0, f[14:0]} : 16'(17'd32768 - {1'b0, f});
    cc  = 32'(cm) * 32'(cm);
    ff  = 32'(f) * 32'(f);
    ff1 = 33'(ff) + 33'd1;
    r.base = ps[32:16];
    r.frac = f;
    r.w0   = aa1[32:1];
    r.w1   = 32'hC000_0000 - cc;
    r.w2   = ff1[32:1];
    return r;
  endfunction

  function automatic axw_t sel_w(axis_t ax, logic [1:0] idx);
    axw_t r;
    case (idx)
      NodeLo:  r = ax.w0;
      NodeMid: r = ax.w1;
      default: r = ax.w2;
    endcase
    return r;
  endfunction

  // derivatives f-1, 1-2f, f in Q.16
  function automatic dw_t sel_dw(logic [FracW-1:0] f, logic [1:0] idx);
    dw_t r;
    case (idx)
      NodeLo:  r = $signed({2'b00, f}) - 18'sd65536;
      NodeMid: r = 18'sd65536 - $signed({1'b0, f, 1'b0});
      default: r = $signed({2'b00, f});
    endcase
    return r;
  endfunction

  // base + offset, saturated to the node range
  function automatic node_t node_sat(logic signed [BaseW-1:0] base, logic [1:0] idx);
    logic signed [17:0] s;
    node_t              r;
    s = $signed({base[16], base} + {16'b0, idx});
    if (s > 18'sd32767) begin
      r = 16'sh7FFF;
    end else if (s < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = s[15:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/mbsw_if.sv
// Valid/ready channel interfaces for particle positions and node results.
// Depends on mbsw_pkg.
interface mbsw_in_if;
  import mbsw_pkg::*;
  logic valid;
  logic ready;
  pos_t pos_x;
  pos_t pos_y;
  pos_t pos_z;
  modport source (output valid, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

interface mbsw_out_if;
  import mbsw_pkg::*;
  logic  valid;
  logic  ready;
  node_t node_x;
  node_t node_y;
  node_t node_z;
  wt_t   weight;
  grad_t grad_x;
  grad_t grad_y;
  grad_t grad_z;
  logic  is_last;
  modport source (output valid, node_x, node_y, node_z, weight, grad_x, grad_y,
                  grad_z, is_last, input ready);
  modport sink   (input valid, node_x, node_y, node_z, weight, grad_x, grad_y,
                  grad_z, is_last, output ready);
endinterface

// File: rtl/mbsw_cfg.sv
// APB-style register file holding the inverse cell size.
// Depends on mbsw_pkg.
module mbsw_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mbsw_pkg::CfgAddrW-1:0]  paddr,
  input  logic [mbsw_pkg::CfgDataW-1:0]  pwdata,
  output logic [mbsw_pkg::CfgDataW-1:0]  prdata,
  output logic                           pready,
  output mbsw_pkg::inv_t                 inv_cell_size
);
  import mbsw_pkg::*;

  inv_t inv_r;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == RegInvCellSize);

  // take a write in the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r <= InvCellSizeRst;
    end else if (wr_en) begin
      inv_r <= pwdata[InvW-1:0];
    end
  end

  // read back the register, zero elsewhere
  always_comb begin
    prdata = '0;
    if (paddr[2] == RegInvCellSize) begin
      prdata = {{(CfgDataW-InvW){1'b0}}, inv_r};
    end
  end

  assign inv_cell_size = inv_r;

endmodule

// File: rtl/mbsw_front.sv
// Front end: accepts particle positions, holds one and forms per-axis base,
// fraction and weights for the queue. Depends on mbsw_pkg and mbsw_in_if.
module mbsw_front (
  input  logic            clk,
  input  logic            rst_n,
  mbsw_in_if.sink         in_ch,
  input  logic            q_full,
  output logic            q_push,
  output mbsw_pkg::part_t q_data
);
  import mbsw_pkg::*;

  logic valid_r;
  logic valid_nxt;
  pos_t px_r;
  pos_t py_r;
  pos_t pz_r;
  logic take;

  assign in_ch.ready = !valid_r || !q_full;
  assign take        = in_ch.valid && in_ch.ready;
  assign q_push      = valid_r && !q_full;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (q_push) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // capture the position on each transfer
  always_ff @(posedge clk) begin
    if (take) begin
      px_r <= in_ch.pos_x;
      py_r <= in_ch.pos_y;
      pz_r <= in_ch.pos_z;
    end
  end

  // classify each axis on the way into the queue
  always_comb begin
    q_data.x = axis_setup(px_r);
    q_data.y = axis_setup(py_r);
    q_data.z = axis_setup(pz_r);
  end

endmodule

// File: rtl/mbsw_queue.sv
// Two-entry queue of classified particles between front and back.
// Depends on mbsw_pkg.
module mbsw_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  mbsw_pkg::part_t push_data,
  input  logic            pop,
  output logic            full,
  output logic            head_valid,
  output mbsw_pkg::part_t head
);
  import mbsw_pkg::*;

  part_t       mem_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  cnt_r;
  logic [1:0]  cnt_nxt;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: rtl/mbsw_back.sv
// Back end: walks the 27 stencil nodes of the queue head and runs the weight
// and gradient products through a stalling pipeline. Depends on mbsw_pkg
// and mbsw_out_if.
module mbsw_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            head_valid,
  input  mbsw_pkg::part_t head,
  output logic            pop,
  input  mbsw_pkg::inv_t  inv_cell_size,
  mbsw_out_if.source      out_ch
);
  import mbsw_pkg::*;

  logic       en;
  logic       take;
  logic       last_node;
  logic [1:0] i_r, j_r, k_r;
  logic [1:0] i_nxt, j_nxt, k_nxt;

  // valid bits, one per stage
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, vo_r;

  // stage 1: selected weights and derivatives
  axw_t  s1_wx_r, s1_wy_r, s1_wz_r;
  dw_t   s1_dx_r, s1_dy_r, s1_dz_r;
  node_t s1_nx_r, s1_ny_r, s1_nz_r;
  logic  s1_last_r;
  // stage 2: raw pair products
  logic [63:0] s2_pxy_r, s2_pxz_r, s2_pyz_r;
  axw_t  s2_wz_r;
  dw_t   s2_dx_r, s2_dy_r, s2_dz_r;
  node_t s2_nx_r, s2_ny_r, s2_nz_r;
  logic  s2_last_r;
  // stage 3: rounded pairs
  axw_t  s3_pxy_r, s3_pxz_r, s3_pyz_r;
  axw_t  s3_wz_r;
  dw_t   s3_dx_r, s3_dy_r, s3_dz_r;
  node_t s3_nx_r, s3_ny_r, s3_nz_r;
  logic  s3_last_r;
  // stage 4: raw weight and gradient magnitudes
  logic [63:0] s4_wt_r;
  logic [48:0] s4_gx_r, s4_gy_r, s4_gz_r;
  logic  s4_sx_r, s4_sy_r, s4_sz_r;
  node_t s4_nx_r, s4_ny_r, s4_nz_r;
  logic  s4_last_r;
  // stage 5: rounded weight and gradient magnitudes
  wt_t   s5_wt_r;
  logic [33:0] s5_gx_r, s5_gy_r, s5_gz_r;
  logic  s5_sx_r, s5_sy_r, s5_sz_r;
  node_t s5_nx_r, s5_ny_r, s5_nz_r;
  logic  s5_last_r;
  // stage 6: scaled by inverse cell size
  logic [62:0] s6_gx_r, s6_gy_r, s6_gz_r;
  logic  s6_sx_r, s6_sy_r, s6_sz_r;
  wt_t   s6_wt_r;
  node_t s6_nx_r, s6_ny_r, s6_nz_r;
  logic  s6_last_r;
  // output register
  grad_t o_gx_r, o_gy_r, o_gz_r;
  wt_t   o_wt_r;
  node_t o_nx_r, o_ny_r, o_nz_r;
  logic  o_last_r;

  // combinational helpers
  logic [64:0] rnd_xy, rnd_xz, rnd_yz, rnd_wt;
  logic [16:0] wt_full;
  logic [16:0] mag_x, mag_y, mag_z;
  logic [49:0] rnd_gx, rnd_gy, rnd_gz;

  // whole pipeline moves unless the output holds an untaken result
  assign en        = !vo_r || out_ch.ready;
  assign take      = en && head_valid;
  assign last_node = (i_r == NodeHi) && (j_r == NodeHi) && (k_r == NodeHi);
  assign pop       = take && last_node;

  // node counter, z fastest
  always_comb begin
    i_nxt = i_r;
    j_nxt = j_r;
    k_nxt = k_r;
    if (take) begin
      if (k_r == NodeHi) begin
        k_nxt = NodeLo;
        if (j_r == NodeHi) begin
          j_nxt = NodeLo;
          i_nxt = (i_r == NodeHi) ? NodeLo : i_r + 2'd1;
        end else begin
          j_nxt = j_r + 2'd1;
        end
      end else begin
        k_nxt = k_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r  <= NodeLo;
      j_r  <= NodeLo;
      k_r  <= NodeLo;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      i_r <= i_nxt;
      j_r <= j_nxt;
      k_r <= k_nxt;
      if (en) begin
        v1_r <= head_valid;
        v2_r <= v1_r;
        v3_r <= v2_r;
        v4_r <= v3_r;
        v5_r <= v4_r;
        v6_r <= v5_r;
        vo_r <= v6_r;
      end
    end
  end

  // rounding and magnitude helpers
  always_comb begin
    rnd_xy  = 65'(s2_pxy_r) + 65'h8000_0000;
    rnd_xz  = 65'(s2_pxz_r) + 65'h8000_0000;
    rnd_yz  = 65'(s2_pyz_r) + 65'h8000_0000;
    rnd_wt  = 65'(s4_wt_r) + 65'h0000_8000_0000_0000;
    wt_full = rnd_wt[64:48];
    mag_x   = s3_dx_r[17] ? 17'(-s3_dx_r) : s3_dx_r[16:0];
    mag_y   = s3_dy_r[17] ? 17'(-s3_dy_r) : s3_dy_r[16:0];
    mag_z   = s3_dz_r[17] ? 17'(-s3_dz_r) : s3_dz_r[16:0];
    rnd_gx  = 50'(s4_gx_r) + 50'd32768;
    rnd_gy  = 50'(s4_gy_r) + 50'd32768;
    rnd_gz  = 50'(s4_gz_r) + 50'd32768;
  end

  // round half away from zero to Q16.16 and clamp to the signed range
  function automatic grad_t grad_fin(logic [62:0] prod, logic neg);
    logic [63:0] s;
    logic [31:0] m;
    grad_t       r;
    s = 64'(prod) + 64'h8000_0000;
    m = s[63:32];
    if (neg) begin
      r = (m > 32'h8000_0000) ? 32'sh8000_0000 : $signed(32'd0 - m);
    end else begin
      r = (m > 32'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(m);
    end
    return r;
  endfunction

  // payload of all stages, advanced together
  always_ff @(posedge clk) begin
    if (en) begin
      // select the node
      s1_wx_r   <= sel_w(head.x, i_r);
      s1_wy_r   <= sel_w(head.y, j_r);
      s1_wz_r   <= sel_w(head.z, k_r);
      s1_dx_r   <= sel_dw(head.x.frac, i_r);
      s1_dy_r   <= sel_dw(head.y.frac, j_r);
      s1_dz_r   <= sel_dw(head.z.frac, k_r);
      s1_nx_r   <= node_sat(head.x.base, i_r);
      s1_ny_r   <= node_sat(head.y.base, j_r);
      s1_nz_r   <= node_sat(head.z.base, k_r);
      s1_last_r <= last_node;
      // pair products
      s2_pxy_r  <= 64'(s1_wx_r) * 64'(s1_wy_r);
      s2_pxz_r  <= 64'(s1_wx_r) * 64'(s1_wz_r);
      s2_pyz_r  <= 64'(s1_wy_r) * 64'(s1_wz_r);
      s2_wz_r   <= s1_wz_r;
      s2_dx_r   <= s1_dx_r;
      s2_dy_r   <= s1_dy_r;
      s2_dz_r   <= s1_dz_r;
      s2_nx_r   <= s1_nx_r;
      s2_ny_r   <= s1_ny_r;
      s2_nz_r   <= s1_nz_r;
      s2_last_r <= s1_last_r;
      // round pairs to Q0.32
      s3_pxy_r  <= rnd_xy[63:32];
      s3_pxz_r  <= rnd_xz[63:32];
      s3_pyz_r  <= rnd_yz[63:32];
      s3_wz_r   <= s2_wz_r;
      s3_dx_r   <= s2_dx_r;
      s3_dy_r   <= s2_dy_r;
      s3_dz_r   <= s2_dz_r;
      s3_nx_r   <= s2_nx_r;
      s3_ny_r   <= s2_ny_r;
      s3_nz_r   <= s2_nz_r;
      s3_last_r <= s2_last_r;
      // weight product and derivative times pair
      s4_wt_r   <= 64'(s3_pxy_r) * 64'(s3_wz_r);
      s4_gx_r   <= 49'(mag_x) * 49'(s3_pyz_r);
      s4_gy_r   <= 49'(mag_y) * 49'(s3_pxz_r);
      s4_gz_r   <= 49'(mag_z) * 49'(s3_pxy_r);
      s4_sx_r   <= s3_dx_r[17];
      s4_sy_r   <= s3_dy_r[17];
      s4_sz_r   <= s3_dz_r[17];
      s4_nx_r   <= s3_nx_r;
      s4_ny_r   <= s3_ny_r;
      s4_nz_r   <= s3_nz_r;
      s4_last_r <= s3_last_r;
      // round weight to Q0.16 and gradient terms to Q.32
      s5_wt_r   <= (wt_full > 17'd65535) ? 16'hFFFF : wt_full[15:0];
      s5_gx_r   <= rnd_gx[49:16];
      s5_gy_r   <= rnd_gy[49:16];
      s5_gz_r   <= rnd_gz[49:16];
      s5_sx_r   <= s4_sx_r;
      s5_sy_r   <= s4_sy_r;
      s5_sz_r   <= s4_sz_r;
      s5_nx_r   <= s4_nx_r;
      s5_ny_r   <= s4_ny_r;
      s5_nz_r   <= s4_nz_r;
      s5_last_r <= s4_last_r;
      // scale by inverse cell size
      s6_gx_r   <= 63'(s5_gx_r) * 63'(inv_cell_size);
      s6_gy_r   <= 63'(s5_gy_r) * 63'(inv_cell_size);
      s6_gz_r   <= 63'(s5_gz_r) * 63'(inv_cell_size);
      s6_sx_r   <= s5_sx_r;
      s6_sy_r   <= s5_sy_r;
      s6_sz_r   <= s5_sz_r;
      s6_wt_r   <= s5_wt_r;
      s6_nx_r   <= s5_nx_r;
      s6_ny_r   <= s5_ny_r;
      s6_nz_r   <= s5_nz_r;
      s6_last_r <= s5_last_r;
      // final rounding and clamp
      o_gx_r    <= grad_fin(s6_gx_r, s6_sx_r);
      o_gy_r    <= grad_fin(s6_gy_r, s6_sy_r);
      o_gz_r    <= grad_fin(s6_gz_r, s6_sz_r);
      o_wt_r    <= s6_wt_r;
      o_nx_r    <= s6_nx_r;
      o_ny_r    <= s6_ny_r;
      o_nz_r    <= s6_nz_r;
      o_last_r  <= s6_last_r;
    end
  end

  assign out_ch.valid   = vo_r;
  assign out_ch.node_x  = o_nx_r;
  assign out_ch.node_y  = o_ny_r;
  assign out_ch.node_z  = o_nz_r;
  assign out_ch.weight  = o_wt_r;
  assign out_ch.grad_x  = o_gx_r;
  assign out_ch.grad_y  = o_gy_r;
  assign out_ch.grad_z  = o_gz_r;
  assign out_ch.is_last = o_last_r;

endmodule

// File: rtl/mpm_quadratic_bspline_weights_core.sv
// Quadratic B-spline MPM weight core: top level.
// Depends on mbsw_pkg, mbsw_if, mbsw_cfg, mbsw_front, mbsw_queue, mbsw_back.
//
// Usage:
//   in_ch takes one particle position (pos_x/y/z, signed Q16.16) per transfer.
//   out_ch gives 27 node results per particle, x slowest and z fastest, each
//   with node coordinates, weight (Q0.16) and gradient (Q16.16); is_last
//   marks the 27th.
//   The APB port holds inv_cell_size at byte address 0; write it only while
//   the block is idle.
// Throughput: one node result per cycle while out_ch is not stalled; the node
//   walk in the back end over the queue head sets this rate.
//   A new position is taken while the previous particle is still being walked.
// Path: a position passes the input register, the queue and seven back-end
//   stages before its first result is valid.
// Reset (rst_n low, synchronous): pipeline and queue empty, inv_cell_size 30.0.
// Stall: a low out_ch.ready with a result waiting freezes the whole back end;
//   the two-entry queue and the input register then fill and in_ch.ready drops.
module mpm_quadratic_bspline_weights_core (
  input  logic                          clk,
  input  logic                          rst_n,
  mbsw_in_if.sink                       in_ch,
  mbsw_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mbsw_pkg::CfgAddrW-1:0] paddr,
  input  logic [mbsw_pkg::CfgDataW-1:0] pwdata,
  output logic [mbsw_pkg::CfgDataW-1:0] prdata,
  output logic                          pready
);
  import mbsw_pkg::*;

  inv_t  inv_cell_size;
  logic  q_full;
  logic  q_push;
  part_t q_data;
  logic  q_pop;
  logic  head_valid;
  part_t head;

  mbsw_cfg u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .inv_cell_size (inv_cell_size)
  );

  mbsw_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_data)
  );

  mbsw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_data),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  mbsw_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (q_pop),
    .inv_cell_size (inv_cell_size),
    .out_ch        (out_ch)
  );

endmodule

// File: tb/mpm_quadratic_bspline_weights_core_test.sv
// Self-checking bench for the quadratic B-spline weight core: drives particle
// positions and scale writes, predicts all 27 node results of every particle.
// Depends on mbsw_pkg, mbsw_if and the core RTL.
module mpm_quadratic_bspline_weights_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mbsw_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int StartHold  = 300;
  localparam int RandPerSet = 28;
  localparam int SpanQ      = 1000 << 16;

  localparam logic [CfgAddrW-1:0] InvAddr      = CfgAddrW'({RegInvCellSize, 2'b00});
  // no register sits behind this word
  localparam logic [CfgAddrW-1:0] SpareRegAddr = CfgAddrW'(3'd4);

  localparam pos_t EdgePos [16] = '{
    32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_8000,
    32'h0000_7FFF, 32'h0001_0000, 32'hFFFF_FFFF, 32'hFFFF_0000,
    32'h7FFE_8000, 32'h8000_8000, 32'h8000_7FFF, 32'hAAAA_AAAA,
    32'h5555_5555, 32'h0000_4000, 32'h0000_C000, 32'h1234_5678
  };
  localparam logic [15:0] EdgeFrac [4] = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF};

  typedef enum int {PaceFree, PaceSendIdle, PaceRecvStall, PaceBoth} pace_e;
  localparam int SendIdlePct [4] = '{0, 80, 0, 33};
  localparam int RecvStallPct[4] = '{0, 0, 80, 33};

  typedef struct packed {
    node_t nx;
    node_t ny;
    node_t nz;
    wt_t   wt;
    grad_t gx;
    grad_t gy;
    grad_t gz;
    logic  last;
  } node_res_t;

  // Stencil predictor and the queue of node results still owed by the core
  class node_ledger;
    inv_t            inv_scale;
    node_res_t       pending[$];
    int              mismatches;
    int              checked;
    longint          ax_base[3];
    longint unsigned ax_w[3][3];
    longint          ax_dw[3][3];

    function new();
      inv_scale = InvCellSizeRst;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) begin
        $display("MISMATCH at %0t: %s", $realtime, msg);
      end
    endfunction

    function void take_write(int idx, logic [31:0] v);
      if (idx == int'(RegInvCellSize)) begin
        inv_scale = v[InvW-1:0];
      end
    endfunction

    // base = floor(p - 0.5), Q0.32 weights and Q.16 slopes of one axis
    function void axis_split(int a, pos_t p);
      longint          ps;
      longint unsigned u;
      longint unsigned f;
      longint unsigned am;
      longint          c;
      ps = longint'(p) - 32768;
      u  = unsigned'(ps + (longint'(1) << 32));
      f  = u & 64'hFFFF;
      am = 64'd65536 - f;
      c  = longint'(f) - 32768;
      ax_base[a]  = longint'(u >> 16) - 65536;
      ax_w[a][0]  = (am * am + 64'd1) >> 1;
      ax_w[a][1]  = (64'd3 << 30) - unsigned'(c * c);
      ax_w[a][2]  = (f * f + 64'd1) >> 1;
      ax_dw[a][0] = longint'(f) - 65536;
      ax_dw[a][1] = 65536 - 2 * longint'(f);
      ax_dw[a][2] = longint'(f);
    endfunction

    function longint unsigned pair32(longint unsigned a, longint unsigned b);
      return (a * b + (64'd1 << 31)) >> 32;
    endfunction

    // shift right with rounding, halves away from zero
    function longint round_away(longint v, int s);
      bit              neg;
      longint unsigned m;
      neg = v < 0;
      m   = neg ? unsigned'(-v) : unsigned'(v);
      m   = (m + (64'd1 << (s - 1))) >> s;
      return neg ? -longint'(m) : longint'(m);
    endfunction

    function grad_t grad_term(longint slope, longint unsigned wpair);
      longint g;
      g = round_away(slope * longint'(wpair), 16);
      g = round_away(g * longint'(inv_scale), 32);
      if (g > 64'sd2147483647) begin
        g = 64'sd2147483647;
      end else if (g < -64'sd2147483648) begin
        g = -64'sd2147483648;
      end
      return grad_t'(g);
    endfunction

    function node_t node_clip(longint v);
      if (v > 32767) begin
        return 16'sh7FFF;
      end else if (v < -32768) begin
        return 16'sh8000;
      end
      return node_t'(v);
    endfunction

    // queue the 27 node results of one accepted particle, z fastest
    function void note_particle(pos_t px, pos_t py, pos_t pz);
      longint unsigned pxy;
      longint unsigned pxz;
      longint unsigned pyz;
      longint unsigned wprod;
      node_res_t       r;
      axis_split(0, px);
      axis_split(1, py);
      axis_split(2, pz);
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          for (int k = 0; k < 3; k++) begin
            pxy   = pair32(ax_w[0][i], ax_w[1][j]);
            pxz   = pair32(ax_w[0][i], ax_w[2][k]);
            pyz   = pair32(ax_w[1][j], ax_w[2][k]);
            wprod = (pxy * ax_w[2][k] + (64'd1 << 47)) >> 48;
            if (wprod > 64'd65535) begin
              wprod = 64'd65535;
            end
            r.nx   = node_clip(ax_base[0] + i);
            r.ny   = node_clip(ax_base[1] + j);
            r.nz   = node_clip(ax_base[2] + k);
            r.wt   = wt_t'(wprod);
            r.gx   = grad_term(ax_dw[0][i], pyz);
            r.gy   = grad_term(ax_dw[1][j], pxz);
            r.gz   = grad_term(ax_dw[2][k], pxy);
            r.last = (i == 2) && (j == 2) && (k == 2);
            pending.insert(pending.size(), r);
          end
        end
      end
    endfunction

    function void check_node(node_res_t got);
      node_res_t exp_r;
      if (pending.size() == 0) begin
        flag($sformatf("node result with no particle outstanding: %p", got));
        return;
      end
      exp_r = pending.pop_front();
      checked++;
      if (got.nx !== exp_r.nx)
        flag($sformatf("result %0d node_x exp %0d got %0d", checked, exp_r.nx, got.nx));
      if (got.ny !== exp_r.ny)
        flag($sformatf("result %0d node_y exp %0d got %0d", checked, exp_r.ny, got.ny));
      if (got.nz !== exp_r.nz)
        flag($sformatf("result %0d node_z exp %0d got %0d", checked, exp_r.nz, got.nz));
      if (got.wt !== exp_r.wt)
        flag($sformatf("result %0d weight exp %0d got %0d", checked, exp_r.wt, got.wt));
      if (got.gx !== exp_r.gx)
        flag($sformatf("result %0d grad_x exp %0d got %0d", checked, exp_r.gx, got.gx));
      if (got.gy !== exp_r.gy)
        flag($sformatf("result %0d grad_y exp %0d got %0d", checked, exp_r.gy, got.gy));
      if (got.gz !== exp_r.gz)
        flag($sformatf("result %0d grad_z exp %0d got %0d", checked, exp_r.gz, got.gz));
      if (got.last !== exp_r.last)
        flag($sformatf("result %0d is_last exp %0b got %0b", checked, exp_r.last, got.last));
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  mbsw_in_if  in_ch ();
  mbsw_out_if out_ch ();

  node_ledger ledger;
  int         idle_pct;
  int         stall_pct;
  int         hold_left;
  int         cycle_count;
  int         particles_sent;
  int         scale_writes;

  mpm_quadratic_bspline_weights_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Receiver: long hold-off when asked, otherwise random stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready = 1'b0;
      hold_left--;
    end else begin
      out_ch.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  // Check every node result transfer
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      ledger.check_node('{out_ch.node_x, out_ch.node_y, out_ch.node_z, out_ch.weight,
                          out_ch.grad_x, out_ch.grad_y, out_ch.grad_z, out_ch.is_last});
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d node results outstanding",
             cycle_count, ledger.pending.size());
    $display("*** FAILED ***");
    $finish;
  end

  // Offer one particle, with random idle cycles ahead of it
  task automatic send_particle(pos_t px, pos_t py, pos_t pz);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      in_ch.pos_x = pos_t'($urandom);
      in_ch.pos_y = pos_t'($urandom);
      in_ch.pos_z = pos_t'($urandom);
    end
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.pos_x = px;
    in_ch.pos_y = py;
    in_ch.pos_z = pz;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    ledger.note_particle(px, py, pz);
    particles_sent++;
  endtask

  // Drop valid and hold until every owed node result has come back
  task automatic pause_sender();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (ledger.pending.size() != 0) @(posedge clk);
  endtask

  // Write one register word, then read inv_cell_size back
  task automatic set_register(logic [CfgAddrW-1:0] addr, logic [CfgDataW-1:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    ledger.take_write(int'(addr >> 2), data);
    scale_writes++;
    @(negedge clk);
    pwrite  = 1'b0;
    penable = 1'b0;
    paddr   = InvAddr;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== CfgDataW'(ledger.inv_scale)) begin
      ledger.flag($sformatf("inv_cell_size readback exp %0d got %0d",
                            ledger.inv_scale, prdata));
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Ordinary grid positions most often, some full range, fraction edges and node limits
  function automatic pos_t pick_pos();
    case ($urandom_range(9))
      0, 1, 2, 3: return pos_t'(int'($urandom_range(0, 2 * SpanQ)) - SpanQ);
      4, 5:       return pos_t'($urandom);
      6:          return pos_t'({16'($urandom), EdgeFrac[$urandom_range(3)]});
      7:          return pos_t'(32'h7FFF_FFFF - $urandom_range(0, 3 << 16));
      default:    return pos_t'(32'h8000_0000 + $urandom_range(0, 3 << 16));
    endcase
  endfunction

  initial begin
    logic [CfgDataW-1:0] scales[6];
    pace_e               pace;
    ledger         = new();
    particles_sent = 0;
    scale_writes   = 0;
    idle_pct       = 0;
    stall_pct      = 0;
    hold_left      = 0;
    rst_n          = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_ch.valid    = 1'b0;
    in_ch.pos_x    = '0;
    in_ch.pos_y    = '0;
    in_ch.pos_z    = '0;
    out_ch.ready   = 1'b0;

    // zero scale, unit, all 29 bits set, top bit alone, random, back to reset value
    scales = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd268435456,
               32'($urandom_range(1, 268435456)), 32'(InvCellSizeRst)};

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: boundary positions rotated over the three axes, reset scale
    for (int i = 0; i < 16; i++) begin
      send_particle(EdgePos[i], EdgePos[(i + 5) % 16], EdgePos[(i + 11) % 16]);
    end
    pause_sender();

    // a write to an unmapped word must leave the scale alone
    set_register(SpareRegAddr, $urandom);

    // random particles under each scale setting and handshake pattern
    for (int ph = 0; ph < 6; ph++) begin
      set_register(InvAddr, scales[ph]);
      pace      = pace_e'(ph % 4);
      idle_pct  = SendIdlePct[pace];
      stall_pct = RecvStallPct[pace];
      if (ph == 0) begin
        hold_left = StartHold;
      end
      for (int n = 0; n < RandPerSet; n++) begin
        if (ph == 4 && n == RandPerSet / 2) begin
          pause_sender();
        end
        send_particle(pick_pos(), pick_pos(), pick_pos());
      end
      pause_sender();
    end

    stall_pct = 0;
    repeat (20) @(posedge clk);

    $display("Run covered %0d particles and %0d node results over %0d register writes,",
             particles_sent, ledger.checked, scale_writes);
    $display("with scale from zero to full width and four idle/stall patterns.");
    if (ledger.mismatches == 0 && ledger.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", ledger.mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
